// ----- hw/rtl/rsf_pkg.sv -----
`default_nettype none

package rsf_pkg;

  // Pixel grid and falloff geometry
  localparam int unsigned CoordMax = 4096;
  localparam int unsigned CoordW   = $clog2(CoordMax);
  localparam int unsigned Radius   = 200;
  localparam int unsigned RadSqLim = (Radius + 1) * (Radius + 1);
  localparam int unsigned SqW      = $clog2(RadSqLim + 1);

  // Division by 200 is a shift by 3 followed by a division by 25.
  // 5243 / 2^17 lies just above 1/25; exact for every quotient below 6400.
  localparam int unsigned DivShift   = 3;
  localparam int unsigned RecipShift = 17;
  localparam logic [12:0] Recip25    = 13'd5243;

  // Configuration port
  localparam int unsigned PaddrW = 3;

  typedef enum logic {
    RegCenterX = 1'b0,
    RegCenterY = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] pixel_col;
    logic [CoordW-1:0] pixel_row;
    logic [7:0]        red_in;
    logic [7:0]        green_in;
    logic [7:0]        blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
  } center_t;

  // Squared distance, clamped so that far pixels take a root of Radius
  typedef struct packed {
    logic [SqW-1:0] sq;
    rgb_t           rgb;
  } dist_t;

  typedef struct packed {
    logic [7:0] d;
    rgb_t       rgb;
  } root_t;

  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] root;
  } sqrt_state_t;

  // One digit of the restoring square root: bring down two bits of the radicand
  function automatic sqrt_state_t sqrt_step(sqrt_state_t s, logic [1:0] pair);
    logic [10:0] acc;
    logic [10:0] trial;
    sqrt_state_t r;
    acc   = {s.rem, pair};
    trial = {1'b0, s.root, 2'b01};
    if (acc >= trial) begin
      r.rem  = 9'(acc - trial);
      r.root = {s.root[6:0], 1'b1};
    end else begin
      r.rem  = acc[8:0];
      r.root = {s.root[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/radial_spotlight_falloff.sv -----
// Radial spotlight with linear falloff, one pixel per transfer.
// Input channel (in_valid_i / in_ready_o / in_data_i): column, row and the
// red, green and blue bytes of one pixel. Output channel (out_valid_o /
// out_ready_i / out_data_o): the three dimmed bytes, in input order.
// Each channel is scaled by (200 - d) / 200, floored, where d is the floored
// distance to the spotlight center; pixels at distance 200 or more go black.
// The center is set over the APB port: register 0 (byte 0x0) is center_x,
// register 1 (byte 0x4) is center_y, both 16-bit two's complement. Write
// them only while no pixel is in flight; pready is tied high.
// The pipeline has seven register stages from input transfer to output
// transfer: offset/abs, squaring, sum and clamp, two square-root stages
// of four bits each, channel multiply, reciprocal divide into the output
// register.
// Throughput is one pixel per cycle while the receiver is ready; every stage carries its own valid bit.
// When the receiver stalls, the output holds and the pipeline fills its
// empty stages before in_ready_o drops, so nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets the
// center to (0, 0).
`default_nettype none

module radial_spotlight_falloff (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire rsf_pkg::pix_in_t           in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output rsf_pkg::pix_out_t               out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rsf_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  rsf_pkg::center_t center;

  // Links between the pipeline sections
  logic           dist_valid, dist_ready;
  rsf_pkg::dist_t dist_data;
  logic           root_valid, root_ready;
  rsf_pkg::root_t root_data;

  // Center registers
  rsf_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .center_o (center)
  );

  // Stages 1-3: squared distance, clamped to the radius
  rsf_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .center_i    (center),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (dist_valid),
    .out_ready_i (dist_ready),
    .out_data_o  (dist_data)
  );

  // Stages 4-5: floored integer square root
  rsf_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dist_valid),
    .in_ready_o  (dist_ready),
    .in_data_i   (dist_data),
    .out_valid_o (root_valid),
    .out_ready_i (root_ready),
    .out_data_o  (root_data)
  );

  // Stages 6-7: scale each channel and divide by the radius
  rsf_dim u_dim (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (root_valid),
    .in_ready_o  (root_ready),
    .in_data_i   (root_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/rsf_cfg.sv -----
`default_nettype none

module rsf_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rsf_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output rsf_pkg::center_t                center_o
);

  logic [15:0]       cx_q, cx_d, cy_q, cy_d;
  rsf_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = rsf_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    if (wr_en) begin
      unique case (idx)
        rsf_pkg::RegCenterX: cx_d = pwdata[15:0];
        rsf_pkg::RegCenterY: cy_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rsf_pkg::RegCenterX: prdata = {16'h0000, cx_q};
      rsf_pkg::RegCenterY: prdata = {16'h0000, cy_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
    end else begin
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

  assign center_o.cx = cx_q;
  assign center_o.cy = cy_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rsf_dist.sv -----
`default_nettype none

module rsf_dist (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rsf_pkg::center_t center_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rsf_pkg::pix_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rsf_pkg::dist_t        out_data_o
);

  logic [2:0] valid_q, valid_d, rdy;

  // Stage 1: absolute offsets
  logic [15:0]   ax_q, ay_q;
  rsf_pkg::rgb_t rgb1_q;
  // Stage 2: squares
  logic [31:0]   sqx_q, sqy_q;
  rsf_pkg::rgb_t rgb2_q;
  // Stage 3: clamped sum
  rsf_pkg::dist_t d3_q;

  logic [17:0] dx, dy, adx, ady;
  logic [32:0] sum;
  logic [rsf_pkg::SqW-1:0] sq_c;

  assign rdy[2]     = !valid_q[2] || out_ready_i;
  assign rdy[1]     = !valid_q[1] || rdy[2];
  assign rdy[0]     = !valid_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  always_comb begin
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    valid_d[1] = rdy[1] ? valid_q[0] : valid_q[1];
    valid_d[2] = rdy[2] ? valid_q[1] : valid_q[2];
  end

  always_comb begin
    dx  = 18'(in_data_i.pixel_col) - {{2{center_i.cx[15]}}, center_i.cx};
    dy  = 18'(in_data_i.pixel_row) - {{2{center_i.cy[15]}}, center_i.cy};
    adx = dx[17] ? 18'(~dx + 18'd1) : dx;
    ady = dy[17] ? 18'(~dy + 18'd1) : dy;
  end

  // Send far pixels to a square whose root is exactly the radius
  always_comb begin
    sum  = 33'(sqx_q) + 33'(sqy_q);
    sq_c = (sum < 33'(rsf_pkg::RadSqLim)) ? sum[rsf_pkg::SqW-1:0]
                                          : rsf_pkg::SqW'(rsf_pkg::Radius * rsf_pkg::Radius);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ax_q   <= adx[15:0];
      ay_q   <= ady[15:0];
      rgb1_q <= '{r: in_data_i.red_in, g: in_data_i.green_in, b: in_data_i.blue_in};
    end
    if (rdy[1]) begin
      sqx_q  <= ax_q * ax_q;
      sqy_q  <= ay_q * ay_q;
      rgb2_q <= rgb1_q;
    end
    if (rdy[2]) begin
      d3_q.sq  <= sq_c;
      d3_q.rgb <= rgb2_q;
    end
  end

  assign out_valid_o = valid_q[2];
  assign out_data_o  = d3_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rsf_sqrt.sv -----
`default_nettype none

module rsf_sqrt (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rsf_pkg::dist_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rsf_pkg::root_t      out_data_o
);

  localparam int unsigned HalfW = rsf_pkg::SqW / 2;

  logic [1:0] valid_q, valid_d, rdy;

  rsf_pkg::sqrt_state_t st1_q, st1_c, st2_c;
  logic [HalfW-1:0]     lo1_q;
  rsf_pkg::rgb_t        rgb1_q;
  rsf_pkg::root_t       r2_q;

  assign rdy[1]     = !valid_q[1] || out_ready_i;
  assign rdy[0]     = !valid_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  always_comb begin
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    valid_d[1] = rdy[1] ? valid_q[0] : valid_q[1];
  end

  // Upper four root bits from the upper radicand byte
  always_comb begin
    st1_c = '0;
    for (int k = HalfW / 2 - 1; k >= 0; k--) begin
      st1_c = rsf_pkg::sqrt_step(st1_c, in_data_i.sq[HalfW + 2*k +: 2]);
    end
  end

  // Lower four root bits from the lower byte
  always_comb begin
    st2_c = st1_q;
    for (int k = HalfW / 2 - 1; k >= 0; k--) begin
      st2_c = rsf_pkg::sqrt_step(st2_c, lo1_q[2*k +: 2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      st1_q  <= st1_c;
      lo1_q  <= in_data_i.sq[HalfW-1:0];
      rgb1_q <= in_data_i.rgb;
    end
    if (rdy[1]) begin
      r2_q.d   <= st2_c.root;
      r2_q.rgb <= rgb1_q;
    end
  end

  assign out_valid_o = valid_q[1];
  assign out_data_o  = r2_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rsf_dim.sv -----
`default_nettype none

module rsf_dim (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rsf_pkg::root_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rsf_pkg::pix_out_t   out_data_o
);

  logic [1:0] valid_q, valid_d, rdy;

  logic [7:0]        factor;
  logic [15:0]       pr_q, pg_q, pb_q;
  rsf_pkg::pix_out_t res_q, res_c;

  // Multiply by the reciprocal of 25 after dropping the factor of 8
  function automatic logic [7:0] div_radius(logic [15:0] p);
    logic [12:0] q;
    logic [25:0] m;
    q = p[15:rsf_pkg::DivShift];
    m = q * rsf_pkg::Recip25;
    return m[rsf_pkg::RecipShift +: 8];
  endfunction

  assign rdy[1]     = !valid_q[1] || out_ready_i;
  assign rdy[0]     = !valid_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  always_comb begin
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    valid_d[1] = rdy[1] ? valid_q[0] : valid_q[1];
  end

  assign factor = 8'(rsf_pkg::Radius) - in_data_i.d;

  always_comb begin
    res_c.red_out   = div_radius(pr_q);
    res_c.green_out = div_radius(pg_q);
    res_c.blue_out  = div_radius(pb_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pr_q <= in_data_i.rgb.r * factor;
      pg_q <= in_data_i.rgb.g * factor;
      pb_q <= in_data_i.rgb.b * factor;
    end
    if (rdy[1]) begin
      res_q <= res_c;
    end
  end

  assign out_valid_o = valid_q[1];
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rsf_checker.sv -----
`default_nettype none

module rsf_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire rsf_pkg::pix_out_t out_data_o,
  input wire logic              pready
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // Drain during reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // A free output end frees the whole pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_o) |-> in_ready_o)
    else $error("input stalled while output is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind radial_spotlight_falloff rsf_checker u_rsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

`default_nettype wire
